// File: hdl/wraqs_pkg.sv
package wraqs_pkg;

	localparam int WINDOW_DEF = 128;
	localparam int GAS_W      = 20;
	localparam int HUM_W      = 14;
	localparam int REG_W      = 14;
	localparam int DW         = 64;
	localparam int MUL_STEPS  = 20;
	localparam int DIV_STEPS  = 64;
	localparam int STEP_W     = 7;
	localparam int ADDR_W     = 4;

	localparam logic [REG_W-1:0] FULL_SCALE   = REG_W'(10000);
	localparam logic [REG_W-1:0] HUM_OPT_RST  = REG_W'(4000);
	localparam logic [REG_W-1:0] HUM_MAX_RST  = REG_W'(2500);
	localparam logic [REG_W-1:0] GAS_MAX_RST  = REG_W'(7500);
	localparam logic [DW-1:0]    OHM_SCALE    = DW'(1000000);
	localparam logic [DW-1:0]    PCT_SCALE    = DW'(100);

	// register indexes (byte address / 4)
	localparam logic [1:0] REG_HUM_OPT = 2'd0;
	localparam logic [1:0] REG_HUM_MAX = 2'd1;
	localparam logic [1:0] REG_GAS_MAX = 2'd2;

	typedef enum logic {
		MDU_MUL,
		MDU_DIV
	} mdu_op_t;

	typedef struct packed {
		logic    start;
		mdu_op_t op;
	} mdu_req_t;

	typedef struct packed {
		logic done;
		logic busy;
	} mdu_rsp_t;

endpackage

// File: hdl/wraqs_mdu.sv
module wraqs_mdu
	import wraqs_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  mdu_req_t      req,
	input  logic [DW-1:0] opa,
	input  logic [DW-1:0] opb,
	output mdu_rsp_t      rsp,
	output logic [DW-1:0] result
);

	logic              busy_q;
	logic              done_q;
	mdu_op_t           op_q;
	logic [STEP_W-1:0] step_q;
	logic [DW-1:0]     acc_q;
	logic [DW-1:0]     x_q;
	logic [DW-1:0]     y_q;
	logic [DW-1:0]     rem_q;

	logic [DW:0]       add_x;
	logic [DW:0]       add_y;
	logic              sub;
	logic [DW+1:0]     sum;
	logic              ge;
	logic [STEP_W-1:0] last_step;

	// one shared adder: shift-add for multiply, shift-subtract for divide
	always_comb begin
		if (op_q == MDU_MUL) begin
			add_x = {1'b0, acc_q};
			add_y = y_q[0] ? {1'b0, x_q} : '0;
			sub   = 1'b0;
		end else begin
			add_x = {rem_q, x_q[DW-1]};
			add_y = {1'b0, y_q};
			sub   = 1'b1;
		end
		sum       = {1'b0, add_x} + ({1'b0, add_y} ^ {(DW+2){sub}}) + (DW+2)'(sub);
		ge        = ~sum[DW+1];
		last_step = (op_q == MDU_MUL) ? STEP_W'(MUL_STEPS - 1) : STEP_W'(DIV_STEPS - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= MDU_MUL;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == last_step) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			acc_q <= '0;
			rem_q <= '0;
			x_q   <= opa;
			y_q   <= opb;
		end else if (busy_q) begin
			if (op_q == MDU_MUL) begin
				acc_q <= sum[DW-1:0];
				x_q   <= {x_q[DW-2:0], 1'b0};
				y_q   <= {1'b0, y_q[DW-1:1]};
			end else begin
				rem_q <= ge ? sum[DW-1:0] : add_x[DW-1:0];
				x_q   <= {x_q[DW-2:0], ge};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.busy = busy_q;
	assign result   = (op_q == MDU_MUL) ? acc_q : x_q;

endmodule

// File: hdl/window_range_air_quality_score_core.sv
// a flat gas range skips the voc multiplies and divide on the shared unit
// throughput: one item at a time; set by the window scan (one entry a cycle from the
//   sample memory) and ten multiplies plus two divides on one shared unit
// reset: arst_n asynchronous active low clears write position, sample count, sequencer and
//   restores register defaults; sample memory is not cleared, entries are read only once written
module window_range_air_quality_score_core
	import wraqs_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// apb config port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	// input items
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [39:0]       s_tdata,  // gas_resistance[19:0], humidity[33:20], zero pad
	// result items
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [31:0]       m_tdata   // voc_percent[13:0], air_quality_score[27:14], zero pad
);

	localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CW = $clog2(WINDOW + 1);

	typedef enum logic [4:0] {
		S_IDLE, S_SCAN, S_DIFF, S_GDMUL, S_POS, S_NEG, S_DSQ, S_DEN, S_SUBT, S_VDIV,
		S_HUM, S_HNMUL, S_HN10K, S_VG, S_VGH, S_HD10K, S_ADD, S_ADIV, S_OUT
	} state_t;

	// config registers
	logic [REG_W-1:0] hum_opt_q, hum_max_q, gas_max_q;

	// sample memory, written on accept, swept during the scan
	logic [GAS_W-1:0] gas_mem [WINDOW];
	logic [HUM_W-1:0] hum_mem [WINDOW];
	logic [GAS_W-1:0] gas_rd_s1;
	logic [HUM_W-1:0] hum_rd_s1;
	logic             rd_valid_s1;

	state_t           state_q;
	logic [AW-1:0]    wpos_q;
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    scan_idx_q;
	logic             first_q;
	logic             issued_q;

	logic [GAS_W-1:0] g_q, gmin_q, gmax_q, d_q, gd_q;
	logic [HUM_W-1:0] rh_q, hmin_q, hmax_q, hr_q;
	logic [REG_W-1:0] factor_q, hd_q, voc_q, aq_q;
	logic [DW-1:0]    t_q, pos_q, den_q, num_q, hn_q, vgh_q;
	logic [2*HUM_W-1:0] neg_q;

	logic             m_tvalid_q;
	logic [REG_W-1:0] m_voc_q, m_aq_q;

	logic             accept;
	logic             cfg_wr;
	logic             scan_rd;
	logic             op_state;
	mdu_req_t         mdu_req;
	mdu_rsp_t         mdu_rsp;
	logic [DW-1:0]    mdu_a, mdu_b, mdu_res;
	logic [REG_W-1:0] res_clamp;

	assign pready   = 1'b1;
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign scan_rd  = (state_q == S_SCAN) && (scan_idx_q != cnt_q);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0, m_aq_q, m_voc_q};

	// config read and write
	always_comb begin
		unique case (paddr[3:2])
			REG_HUM_OPT: prdata = {18'b0, hum_opt_q};
			REG_HUM_MAX: prdata = {18'b0, hum_max_q};
			REG_GAS_MAX: prdata = {18'b0, gas_max_q};
			default:     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hum_opt_q <= HUM_OPT_RST;
			hum_max_q <= HUM_MAX_RST;
			gas_max_q <= GAS_MAX_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_HUM_OPT: hum_opt_q <= pwdata[REG_W-1:0];
				REG_HUM_MAX: hum_max_q <= pwdata[REG_W-1:0];
				REG_GAS_MAX: gas_max_q <= pwdata[REG_W-1:0];
				default:     ;
			endcase
		end
	end

	// memory: one write port on accept, one registered read port for the scan
	always_ff @(posedge clk) begin
		if (accept) begin
			gas_mem[wpos_q] <= s_tdata[GAS_W-1:0];
			hum_mem[wpos_q] <= s_tdata[GAS_W+HUM_W-1:GAS_W];
		end
		gas_rd_s1 <= gas_mem[scan_idx_q[AW-1:0]];
		hum_rd_s1 <= hum_mem[scan_idx_q[AW-1:0]];
	end

	// operand select for the shared multiply/divide unit
	always_comb begin
		op_state = 1'b1;
		mdu_a    = '0;
		mdu_b    = '0;
		mdu_req.op = MDU_MUL;
		unique case (state_q)
			S_GDMUL: begin mdu_a = DW'(gd_q);     mdu_b = DW'(d_q);       end
			S_POS:   begin mdu_a = t_q;           mdu_b = OHM_SCALE;      end
			S_NEG:   begin mdu_a = DW'(hr_q);     mdu_b = DW'(rh_q);      end
			S_DSQ:   begin mdu_a = DW'(d_q);      mdu_b = DW'(d_q);       end
			S_DEN:   begin mdu_a = t_q;           mdu_b = PCT_SCALE;      end
			S_VDIV:  begin mdu_a = num_q;         mdu_b = den_q;  mdu_req.op = MDU_DIV; end
			S_HNMUL: begin mdu_a = DW'(factor_q); mdu_b = DW'(hum_max_q); end
			S_HN10K: begin mdu_a = t_q;           mdu_b = DW'(FULL_SCALE); end
			S_VG:    begin mdu_a = DW'(voc_q);    mdu_b = DW'(gas_max_q); end
			S_VGH:   begin mdu_a = t_q;           mdu_b = DW'(hd_q);      end
			S_HD10K: begin mdu_a = DW'(hd_q);     mdu_b = DW'(FULL_SCALE); end
			S_ADIV:  begin mdu_a = num_q;         mdu_b = den_q;  mdu_req.op = MDU_DIV; end
			default: op_state = 1'b0;
		endcase
		mdu_req.start = op_state && !issued_q;
		res_clamp = (mdu_res > DW'(FULL_SCALE)) ? FULL_SCALE : mdu_res[REG_W-1:0];
	end

	wraqs_mdu u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mdu_req),
		.opa    (mdu_a),
		.opb    (mdu_b),
		.rsp    (mdu_rsp),
		.result (mdu_res)
	);

	// sequencer: accept, scan window, then walk the arithmetic on the shared unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wpos_q      <= '0;
			cnt_q       <= '0;
			scan_idx_q  <= '0;
			first_q     <= 1'b0;
			issued_q    <= 1'b0;
			rd_valid_s1 <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			rd_valid_s1 <= scan_rd;
			// the output state reloads the register itself
			if (m_tvalid_q && m_tready && state_q != S_OUT)
				m_tvalid_q <= 1'b0;
			if (mdu_req.start)
				issued_q <= 1'b1;
			if (mdu_rsp.done)
				issued_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						g_q        <= s_tdata[GAS_W-1:0];
						rh_q       <= s_tdata[GAS_W+HUM_W-1:GAS_W];
						wpos_q     <= (wpos_q == AW'(WINDOW - 1)) ? '0 : wpos_q + 1'b1;
						if (cnt_q != CW'(WINDOW))
							cnt_q <= cnt_q + 1'b1;
						scan_idx_q <= '0;
						first_q    <= 1'b1;
						state_q    <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_rd)
						scan_idx_q <= scan_idx_q + 1'b1;
					if (rd_valid_s1) begin
						first_q <= 1'b0;
						if (first_q || gas_rd_s1 < gmin_q) gmin_q <= gas_rd_s1;
						if (first_q || gas_rd_s1 > gmax_q) gmax_q <= gas_rd_s1;
						if (first_q || hum_rd_s1 < hmin_q) hmin_q <= hum_rd_s1;
						if (first_q || hum_rd_s1 > hmax_q) hmax_q <= hum_rd_s1;
					end
					if (!scan_rd && !rd_valid_s1)
						state_q <= S_DIFF;
				end
				S_DIFF: begin
					d_q  <= gmax_q - gmin_q;
					hr_q <= hmax_q - hmin_q;
					gd_q <= g_q - gmin_q;
					if (gmax_q == gmin_q) begin
						voc_q   <= FULL_SCALE;
						state_q <= S_HUM;
					end else begin
						state_q <= S_GDMUL;
					end
				end
				S_GDMUL: if (mdu_rsp.done) begin t_q   <= mdu_res; state_q <= S_POS; end
				S_POS:   if (mdu_rsp.done) begin pos_q <= mdu_res; state_q <= S_NEG; end
				S_NEG:   if (mdu_rsp.done) begin
					neg_q   <= mdu_res[2*HUM_W-1:0];
					state_q <= S_DSQ;
				end
				S_DSQ:   if (mdu_rsp.done) begin t_q   <= mdu_res; state_q <= S_DEN; end
				S_DEN:   if (mdu_rsp.done) begin den_q <= mdu_res; state_q <= S_SUBT; end
				S_SUBT: begin
					// negative numerator gives zero
					if (pos_q <= DW'(neg_q)) begin
						voc_q   <= '0;
						state_q <= S_HUM;
					end else begin
						num_q   <= pos_q - DW'(neg_q);
						state_q <= S_VDIV;
					end
				end
				S_VDIV:  if (mdu_rsp.done) begin voc_q <= res_clamp; state_q <= S_HUM; end
				S_HUM: begin
					// humidity score as factor * max_points / hd
					if (rh_q == hum_opt_q) begin
						factor_q <= REG_W'(1);
						hd_q     <= REG_W'(1);
					end else if (rh_q < hum_opt_q) begin
						factor_q <= rh_q;
						hd_q     <= hum_opt_q;
					end else if (rh_q >= FULL_SCALE || hum_opt_q >= FULL_SCALE) begin
						factor_q <= '0;
						hd_q     <= REG_W'(1);
					end else begin
						factor_q <= FULL_SCALE - rh_q;
						hd_q     <= FULL_SCALE - hum_opt_q;
					end
					state_q <= S_HNMUL;
				end
				S_HNMUL: if (mdu_rsp.done) begin t_q   <= mdu_res; state_q <= S_HN10K; end
				S_HN10K: if (mdu_rsp.done) begin hn_q  <= mdu_res; state_q <= S_VG; end
				S_VG:    if (mdu_rsp.done) begin t_q   <= mdu_res; state_q <= S_VGH; end
				S_VGH:   if (mdu_rsp.done) begin vgh_q <= mdu_res; state_q <= S_HD10K; end
				S_HD10K: if (mdu_rsp.done) begin den_q <= mdu_res; state_q <= S_ADD; end
				S_ADD: begin
					num_q   <= hn_q + vgh_q;
					state_q <= S_ADIV;
				end
				S_ADIV:  if (mdu_rsp.done) begin aq_q <= res_clamp; state_q <= S_OUT; end
				S_OUT: begin
					// hold until the output register is free
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_voc_q    <= voc_q;
						m_aq_q     <= aq_q;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_cnt_sat: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(WINDOW))
		else $error("sample count beyond window");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> scan_idx_q <= cnt_q && cnt_q != '0)
		else $error("scan index past written entries");

	a_range_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIFF |-> gmin_q <= gmax_q && hmin_q <= hmax_q)
		else $error("window min above max");

	a_done_issued: assert property (@(posedge clk) disable iff (!arst_n)
		mdu_rsp.done |-> issued_q && op_state)
		else $error("arithmetic result without request");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> m_voc_q <= FULL_SCALE && m_aq_q <= FULL_SCALE)
		else $error("result beyond full scale");

endmodule
